// File: design/jnre_pkg.sv
// Shared constants and control/status types for the JTAG nibble run-length encoder.
package jnre_pkg;

  localparam int MAX_RUN_DEFAULT = 1024;

  localparam logic [1:0] CMD_CLOCK = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [3:0] CODE_FLUSH = 4'hA;
  localparam logic [3:0] CODE_REP   = 4'hC;
  localparam logic [3:0] CODE_RST   = 4'h8;

  typedef struct packed {
    logic load;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic rem_last;
    logic push_ok;
  } dp_status_t;

endpackage

// File: design/jtag_nibble_rle_encoder_top.sv
// Top level of the JTAG nibble run-length encoder.
// An item that writes no nibble leaves the sequencer idle; otherwise input stalls while it pushes its N nibbles,
// where N is its nibble count (at most 3 + digits of MAX_RUN - 1 in base 4, so 8 by default).
// The first byte of an item is written to the output register by the push that completes it;
// output stalls hold the sequencer while that register is full and the next push would complete a byte.
// Synchronous reset clears the run, the half byte and the output register; no clearing pass.
module jtag_nibble_rle_encoder_top #(
  parameter int MAX_RUN = jnre_pkg::MAX_RUN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic       tms,
  input  logic       tdi,
  input  logic       capture,
  input  logic       srst,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       packet_end,
  output logic       last
);

  jnre_pkg::ctrl_cmd_t  ctrl_cmd;
  jnre_pkg::dp_status_t dp_status;

  jnre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd_out  (ctrl_cmd)
  );

  jnre_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .tms        (tms),
    .tdi        (tdi),
    .capture    (capture),
    .srst       (srst),
    .cmd_in     (ctrl_cmd),
    .status     (dp_status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .last       (last)
  );

endmodule

// File: design/jnre_ctrl.sv
// Controller state machine that sequences the nibbles of one input item.
module jnre_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  jnre_pkg::dp_status_t status,
  output jnre_pkg::ctrl_cmd_t  cmd_out
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    cmd_out.load = 1'b0;
    cmd_out.push = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_out.load = 1'b1;
          if (!status.total_zero) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        cmd_out.push = status.push_ok;
        if (status.push_ok && status.rem_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/jnre_datapath.sv
// Datapath with run tracking, repeat-digit generation, nibble packing and the output register.
module jnre_datapath #(
  parameter int MAX_RUN = jnre_pkg::MAX_RUN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           cmd,
  input  logic                 tms,
  input  logic                 tdi,
  input  logic                 capture,
  input  logic                 srst,
  input  jnre_pkg::ctrl_cmd_t  cmd_in,
  output jnre_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 packet_end,
  output logic                 last
);

  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int DIGITS = ($clog2(MAX_RUN) + 1) / 2;
  localparam int CT_W   = 2 * DIGITS;
  localparam int REM_W  = $clog2(DIGITS + 4);

  logic [3:0]       held_code;
  logic [RUN_W-1:0] run_count;
  logic [3:0]       half_nibble;
  logic             half_valid;
  logic [3:0]       emit_code;
  logic             head_pend;
  logic [CT_W-1:0]  digits;
  logic [REM_W-1:0] rem;
  logic             item_flush;

  logic [3:0]       code;
  logic             is_add;
  logic             is_flush;
  logic             emit;
  logic [RUN_W-1:0] run_m1;
  logic [CT_W-1:0]  ct;
  logic [REM_W-1:0] run_nibs;
  logic [REM_W-1:0] flush_nibs;
  logic [REM_W-1:0] total;
  logic [3:0]       nib;
  logic             byte_done;

  function automatic logic [REM_W-1:0] digit_count(input logic [CT_W-1:0] v);
    logic [REM_W-1:0] n;
    n = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[2*i +: 2] != 2'b00) begin
        n = REM_W'(i + 1);
      end
    end
    return n;
  endfunction

  always_comb begin
    if (cmd == jnre_pkg::CMD_CLOCK) begin
      code = {1'b0, capture, tms, tdi};
    end else begin
      code = jnre_pkg::CODE_RST | {3'b000, srst};
    end
    is_add   = (cmd == jnre_pkg::CMD_CLOCK) || (cmd == jnre_pkg::CMD_RESET);
    is_flush = (cmd == jnre_pkg::CMD_DRAIN);
    run_m1   = run_count - RUN_W'(1);
    ct       = CT_W'(run_m1);
    emit     = (run_count != '0) &&
               (is_flush || (is_add && !((code == held_code) &&
                                         (run_count < RUN_W'(MAX_RUN)))));
    run_nibs = emit ? (REM_W'(1) + digit_count(ct)) : '0;
    if (!is_flush) begin
      flush_nibs = '0;
    end else if (half_valid == run_nibs[0]) begin
      flush_nibs = REM_W'(2);
    end else begin
      flush_nibs = REM_W'(1);
    end
    total = run_nibs + flush_nibs;
  end

  always_comb begin
    if (head_pend) begin
      nib = emit_code;
    end else if (digits != '0) begin
      nib = jnre_pkg::CODE_REP | {2'b00, digits[1:0]};
    end else begin
      nib = jnre_pkg::CODE_FLUSH;
    end
  end

  assign status.total_zero = (total == '0);
  assign status.rem_last   = (rem == REM_W'(1));
  assign status.push_ok    = !half_valid || !out_valid || !out_stall;
  assign byte_done         = cmd_in.push && half_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_code  <= '0;
      run_count  <= '0;
      half_valid <= 1'b0;
      head_pend  <= 1'b0;
      digits     <= '0;
      rem        <= '0;
      item_flush <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd_in.load) begin
        head_pend  <= emit;
        emit_code  <= held_code;
        digits     <= emit ? ct : '0;
        rem        <= total;
        item_flush <= is_flush;
        if (is_flush) begin
          run_count <= '0;
        end else if (is_add) begin
          if ((code == held_code) && (run_count != '0) &&
              (run_count < RUN_W'(MAX_RUN))) begin
            run_count <= run_count + RUN_W'(1);
          end else begin
            held_code <= code;
            run_count <= RUN_W'(1);
          end
        end
      end
      if (cmd_in.push) begin
        rem <= rem - REM_W'(1);
        if (head_pend) begin
          head_pend <= 1'b0;
        end else if (digits != '0) begin
          digits <= digits >> 2;
        end
        if (!half_valid) begin
          half_nibble <= nib;
          half_valid  <= 1'b1;
        end else begin
          half_valid <= 1'b0;
        end
      end
      if (byte_done) begin
        out_valid  <= 1'b1;
        out_byte   <= {half_nibble, nib};
        last       <= (rem < REM_W'(3));
        packet_end <= item_flush && (rem < REM_W'(3));
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
